FILE: hdl/cbt_pkg.sv
// shared constants and codes of the circuit breaker table
package cbt_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_TIME_BITS = 32;

  localparam int CMD_W      = 2;
  localparam int IDX_FIELD_W = 6;
  localparam int NOW_W      = 32;
  localparam int MODE_W     = 2;
  localparam int TALLY_W    = 16;
  localparam int THRESH_W   = 16;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TALLY_W-1:0]   TALLY_MAX     = '1;
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd30000;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAILURE = 2'd2
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_TIMEOUT   = 2'd2
  } reg_idx_t;

endpackage

FILE: hdl/cbt_if.sv
// channel interfaces of the circuit breaker table

// item channel: command, entry and current time
interface cbt_in_if;
  logic                             valid;
  logic                             ready;
  logic [cbt_pkg::CMD_W-1:0]        cmd;
  logic [cbt_pkg::IDX_FIELD_W-1:0]  entry_index;
  logic [cbt_pkg::NOW_W-1:0]        now_ms;

  modport source (output valid, cmd, entry_index, now_ms, input ready);
  modport sink   (input valid, cmd, entry_index, now_ms, output ready);
endinterface

// result channel
interface cbt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          allowed;
  logic [cbt_pkg::MODE_W-1:0]    mode;
  logic [cbt_pkg::TALLY_W-1:0]   failures;
  logic [cbt_pkg::TALLY_W-1:0]   successes;
  logic                          just_opened;
  logic                          just_closed;

  modport source (output valid, allowed, mode, failures, successes, just_opened,
                  just_closed, input ready);
  modport sink   (input valid, allowed, mode, failures, successes, just_opened,
                  just_closed, output ready);
endinterface

// register write channel
interface cbt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbt_pkg::CFG_IDX_W-1:0]     index;
  logic [cbt_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/cbt_ram.sv
// generic single-write, single-read ram with registered read
module cbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/circuit_breaker_table.sv
// circuit breaker table: per-entry closed/open/half-open breakers in one ram
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------------
//  in_ch    | in  | valid / ready    | cmd, entry_index, now_ms
//  out_ch   | out | valid / ready    | allowed, mode, failures, successes,
//           |     |                  | just_opened, just_closed
//  cfg_ch   | in  | valid / ready    | index, data (ready is always high)
//
//  one item per cycle sustained while out_ch.ready is high; a result passes the item stage and the output register
//  each item is one read-modify-write of the entry ram, the write of one item
//  forwarded to the next item that reads the same entry
//  after reset a clearing pass sets every entry to closed and
//  zero; in_ch.ready stays low during it, cfg writes are taken throughout
//  a stalled result holds the item under work, which holds the input side
module circuit_breaker_table #(
  parameter int ENTRIES   = cbt_pkg::DEF_ENTRIES,
  parameter int TIME_BITS = cbt_pkg::DEF_TIME_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  cbt_in_if.sink     in_ch,
  cbt_out_if.source  out_ch,
  cbt_cfg_if.sink    cfg_ch
);

  import cbt_pkg::*;

  localparam int IDX_W   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int ENTRY_W = MODE_W + 2 * TALLY_W + TIME_BITS;
  localparam int CMP_W   = TIME_BITS > TIMEOUT_W ? TIME_BITS : TIMEOUT_W;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ENTRIES - 1);

  // config registers
  logic                 enabled_r;
  logic [THRESH_W-1:0]  threshold_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // clearing pass
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_addr_r;

  // item under work (ram data arrives this cycle)
  logic                   s1_valid_r;
  logic [CMD_W-1:0]       s1_cmd_r;
  logic [IDX_FIELD_W-1:0] s1_idx_r;
  logic [TIME_BITS-1:0]   s1_now_r;

  // last entry written, for forwarding
  logic               last_wr_valid_r;
  logic [IDX_W-1:0]   last_wr_addr_r;
  logic [ENTRY_W-1:0] last_wr_data_r;

  // output register
  logic               out_valid_r;
  logic               out_allowed_r;
  logic [MODE_W-1:0]  out_mode_r;
  logic [TALLY_W-1:0] out_failures_r;
  logic [TALLY_W-1:0] out_successes_r;
  logic               out_opened_r;
  logic               out_closed_r;

  logic               in_xfer;
  logic               s1_adv;
  logic [IDX_W-1:0]   s1_addr;
  logic               in_range;
  logic               fwd_hit;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] cur_entry;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  logic [MODE_W-1:0]    cur_mode;
  logic [TALLY_W-1:0]   cur_fail;
  logic [TALLY_W-1:0]   cur_succ;
  logic [TIME_BITS-1:0] cur_stamp;
  logic [TALLY_W-1:0]   fail_inc;
  logic [TALLY_W-1:0]   succ_inc;
  logic [TIME_BITS-1:0] elapsed;
  logic                 timed_out;

  logic [MODE_W-1:0]    mode_nxt;
  logic [TALLY_W-1:0]   fail_nxt;
  logic [TALLY_W-1:0]   succ_nxt;
  logic [TIME_BITS-1:0] stamp_nxt;
  logic                 allowed_nxt;
  logic                 opened_nxt;
  logic                 closed_nxt;

  // handshakes
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign cfg_ch.ready = 1'b1;

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      threshold_r <= THRESH_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_ENABLED:   enabled_r   <= cfg_ch.data[0];
        REG_THRESHOLD: threshold_r <= cfg_ch.data[THRESH_W-1:0];
        REG_TIMEOUT:   timeout_r   <= cfg_ch.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass walks every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // entry ram: {mode, failures, successes, mode change time}
  assign s1_addr   = IDX_W'(s1_idx_r);
  assign in_range  = 32'(s1_idx_r) < 32'(ENTRIES);
  assign ram_we    = clr_active_r || (s1_adv && in_range);
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr;
  assign ram_wdata = clr_active_r ? '0 : {mode_nxt, fail_nxt, succ_nxt, stamp_nxt};

  cbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (IDX_W'(in_ch.entry_index)),
    .rdata (ram_rdata)
  );

  // item stage: captured at transfer, held while the result is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_ch.cmd;
      s1_idx_r <= in_ch.entry_index;
      s1_now_r <= TIME_BITS'(in_ch.now_ms);
    end
  end

  // the ram returns the old entry when it was written on the read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wr_valid_r <= 1'b0;
    end else if (s1_adv && in_range) begin
      last_wr_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_range) begin
      last_wr_addr_r <= s1_addr;
      last_wr_data_r <= ram_wdata;
    end
  end

  assign fwd_hit   = last_wr_valid_r && (last_wr_addr_r == s1_addr);
  assign cur_entry = fwd_hit ? last_wr_data_r : ram_rdata;

  // breaker update
  always_comb begin
    cur_mode  = cur_entry[ENTRY_W-1 -: MODE_W];
    cur_fail  = cur_entry[ENTRY_W-MODE_W-1 -: TALLY_W];
    cur_succ  = cur_entry[TIME_BITS+TALLY_W-1 -: TALLY_W];
    cur_stamp = cur_entry[TIME_BITS-1:0];

    fail_inc  = (cur_fail == TALLY_MAX) ? cur_fail : cur_fail + 1'b1;
    succ_inc  = (cur_succ == TALLY_MAX) ? cur_succ : cur_succ + 1'b1;
    elapsed   = s1_now_r - cur_stamp;
    timed_out = CMP_W'(elapsed) > CMP_W'(timeout_r);

    mode_nxt    = cur_mode;
    fail_nxt    = cur_fail;
    succ_nxt    = cur_succ;
    stamp_nxt   = cur_stamp;
    allowed_nxt = 1'b0;
    opened_nxt  = 1'b0;
    closed_nxt  = 1'b0;

    unique case (cmd_t'(s1_cmd_r))
      CMD_REQUEST: begin
        if (!enabled_r || cur_mode != MODE_OPEN) begin
          allowed_nxt = 1'b1;
        end else if (timed_out) begin
          mode_nxt    = MODE_HALF;
          stamp_nxt   = s1_now_r;
          allowed_nxt = 1'b1;
        end
      end
      CMD_SUCCESS: begin
        succ_nxt = succ_inc;
        if (cur_mode == MODE_HALF) begin
          mode_nxt   = MODE_CLOSED;
          fail_nxt   = '0;
          stamp_nxt  = s1_now_r;
          closed_nxt = 1'b1;
        end
      end
      CMD_FAILURE: begin
        fail_nxt = fail_inc;
        if ((cur_mode == MODE_CLOSED && fail_inc >= threshold_r) ||
            cur_mode == MODE_HALF) begin
          mode_nxt   = MODE_OPEN;
          stamp_nxt  = s1_now_r;
          opened_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register, an index beyond the table reports all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_allowed_r   <= in_range && allowed_nxt;
      out_mode_r      <= in_range ? mode_nxt : '0;
      out_failures_r  <= in_range ? fail_nxt : '0;
      out_successes_r <= in_range ? succ_nxt : '0;
      out_opened_r    <= in_range && opened_nxt;
      out_closed_r    <= in_range && closed_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.allowed     = out_allowed_r;
  assign out_ch.mode        = out_mode_r;
  assign out_ch.failures    = out_failures_r;
  assign out_ch.successes   = out_successes_r;
  assign out_ch.just_opened = out_opened_r;
  assign out_ch.just_closed = out_closed_r;

  // no item enters before the clearing pass is over
  a_no_xfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !clr_active_r)
    else $error("item transfer during clearing pass");

  // a finished item always lands in the output register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("finished item lost before output register");

  // the forwarding register tracks the entry just written back
  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && in_range) |=> (last_wr_valid_r && last_wr_addr_r == $past(s1_addr)))
    else $error("forwarding register out of step with write back");

  // a result that opened the entry reports it open
  a_opened_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_opened_r) |-> (out_mode_r == MODE_OPEN && !out_closed_r))
    else $error("just_opened without open mode");

  // a result that closed the entry reports it closed with no failures
  a_closed_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_closed_r) |-> (out_mode_r == MODE_CLOSED && out_failures_r == '0))
    else $error("just_closed with wrong mode or failures");

endmodule
